// ===== hdl/tape_image_rle_unpacker_macros.svh =====
// Assertion macros for the tape image RLE unpacker.
// Used by modules that write concurrent checks; expects clk and rst_n in scope.
`ifndef TAPE_IMAGE_RLE_UNPACKER_MACROS_SVH
`define TAPE_IMAGE_RLE_UNPACKER_MACROS_SVH

// same-cycle implication
`define TIRLE_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TIRLE_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tirle_pkg.sv =====
// Package for the tape image RLE unpacker: phase codes, result record, sizes.
// No dependencies.
package tirle_pkg;

    typedef enum logic [3:0] {
        PH_BANK  = 4'd0,
        PH_COUNT = 4'd1,
        PH_HDR0  = 4'd2,
        PH_HDR1  = 4'd3,
        PH_HDR2  = 4'd4,
        PH_HDR3  = 4'd5,
        PH_HDR4  = 4'd6,
        PH_HDR5  = 4'd7,
        PH_CTRL  = 4'd8,
        PH_VALUE = 4'd9,
        PH_LIT   = 4'd10,
        PH_IDLE  = 4'd11,
        PH_HALT  = 4'd12
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] run_length;
        logic       is_prefix;
        logic       block_end;
        logic       all_done;
        logic       overrun_error;
        logic       last;
    } result_t;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int QROOM    = QDEPTH - 2;

    localparam logic [7:0] COUNT_MASK = 8'h7F;
    localparam logic [7:0] RUN_FLAG   = 8'h80;

endpackage

// ===== hdl/tape_image_rle_unpacker.sv =====
// Top level of the tape image RLE unpacker: input register, phase machine, result queue.
// Depends on tirle_pkg and tape_image_rle_unpacker_macros.svh.
//
//  channel | direction | payload
//  --------+-----------+-----------------------------------------------------------
//  in      | sink      | in_byte
//  out     | source    | out_byte, run_length, is_prefix, block_end, all_done,
//          |           | overrun_error, last
//
// One input byte per cycle while the queue has room, through the input register; its
// results enter a four-entry queue when that register advances. Header-end bytes give
// two results, which leave in turn through the single queue read port.
// Reset clears phase, counters and the queue. A stalled output fills the queue, which
// then holds the input register and drops in_ready.
`include "tape_image_rle_unpacker_macros.svh"

module tape_image_rle_unpacker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [7:0] run_length,
    output logic       is_prefix,
    output logic       block_end,
    output logic       all_done,
    output logic       overrun_error,
    output logic       last
);
    import tirle_pkg::*;

    logic [7:0]         byte_reg;
    logic               byte_valid_reg;
    phase_t             phase_reg, phase_next;
    logic [7:0]         files_left_reg, files_left_next;
    logic [7:0]         size_low_reg, size_low_next;
    logic [15:0]        remaining_reg, remaining_next;
    logic [7:0]         literal_left_reg, literal_left_next;
    logic [7:0]         run_count_reg, run_count_next;

    result_t            queue_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    logic               advance;
    logic               pop;
    logic [1:0]         push;
    result_t            res0, res1;

    logic [7:0]         len8;
    logic [15:0]        sub_len, rem_sub;
    logic [7:0]         files_dec;
    logic               end_blk, end_done;
    result_t            head;

    assign advance  = byte_valid_reg && (count_reg <= QCNT_W'(QROOM));
    assign in_ready = !byte_valid_reg || advance;
    assign pop      = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            byte_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_BANK;
            files_left_reg   <= '0;
            size_low_reg     <= '0;
            remaining_reg    <= '0;
            literal_left_reg <= '0;
            run_count_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            files_left_reg   <= files_left_next;
            size_low_reg     <= size_low_next;
            remaining_reg    <= remaining_next;
            literal_left_reg <= literal_left_next;
            run_count_reg    <= run_count_next;
        end
    end

    assign len8      = {((byte_reg & COUNT_MASK) == 8'd0), byte_reg[6:0]};
    assign files_dec = files_left_reg - 8'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        files_left_next   = files_left_reg;
        size_low_next     = size_low_reg;
        remaining_next    = remaining_reg;
        literal_left_next = literal_left_reg;
        run_count_next    = run_count_reg;
        push              = 2'd0;
        res0              = '0;
        res1              = '0;
        sub_len           = '0;
        end_blk           = 1'b0;
        end_done          = 1'b0;

        case (phase_reg)
            PH_VALUE: sub_len = {8'd0, run_count_reg};
            PH_LIT:   sub_len = 16'd1;
            default:  sub_len = '0;
        endcase
        rem_sub = remaining_reg - sub_len;

        case (phase_reg)
            PH_BANK:
            begin
                phase_next = PH_COUNT;
            end
            PH_COUNT:
            begin
                files_left_next = byte_reg;
                phase_next      = (byte_reg == 8'd0) ? PH_IDLE : PH_HDR0;
            end
            PH_HDR0, PH_HDR1, PH_HDR3, PH_HDR4:
            begin
                if (phase_reg == PH_HDR3)
                begin
                    remaining_next = {byte_reg, size_low_reg};
                end
                phase_next = phase_t'(phase_reg + 4'd1);
            end
            PH_HDR2:
            begin
                size_low_next = byte_reg;
                phase_next    = PH_HDR3;
            end
            PH_HDR5:
            begin
                phase_next = PH_CTRL;
                if (remaining_reg == 16'd0)
                begin
                    end_blk         = 1'b1;
                    end_done        = (files_dec == 8'd0);
                    files_left_next = files_dec;
                    phase_next      = end_done ? PH_IDLE : PH_HDR0;
                end
                push = 2'd2;
                res0 = '{out_byte: remaining_reg[7:0], run_length: 8'd1, is_prefix: 1'b1,
                         block_end: 1'b0, all_done: 1'b0, overrun_error: 1'b0,
                         last: 1'b0};
                res1 = '{out_byte: remaining_reg[15:8], run_length: 8'd1, is_prefix: 1'b1,
                         block_end: end_blk, all_done: end_done, overrun_error: 1'b0,
                         last: 1'b1};
            end
            PH_CTRL:
            begin
                if ({8'd0, len8} > remaining_reg)
                begin
                    phase_next = PH_HALT;
                    push       = 2'd1;
                    res0       = '{out_byte: 8'd0, run_length: 8'd0, is_prefix: 1'b0,
                                   block_end: 1'b0, all_done: 1'b0, overrun_error: 1'b1,
                                   last: 1'b1};
                end
                else if ((byte_reg & RUN_FLAG) != 8'd0)
                begin
                    run_count_next = len8;
                    phase_next     = PH_VALUE;
                end
                else
                begin
                    literal_left_next = len8;
                    phase_next        = PH_LIT;
                end
            end
            PH_VALUE, PH_LIT:
            begin
                remaining_next = rem_sub;
                if (phase_reg == PH_LIT)
                begin
                    literal_left_next = literal_left_reg - 8'd1;
                    phase_next = (literal_left_next == 8'd0) ? PH_CTRL : PH_LIT;
                end
                else
                begin
                    phase_next = PH_CTRL;
                end
                if (rem_sub == 16'd0)
                begin
                    end_blk         = 1'b1;
                    end_done        = (files_dec == 8'd0);
                    files_left_next = files_dec;
                    phase_next      = end_done ? PH_IDLE : PH_HDR0;
                end
                push = 2'd1;
                res0 = '{out_byte: byte_reg,
                         run_length: (phase_reg == PH_LIT) ? 8'd1 : run_count_reg,
                         is_prefix: 1'b0, block_end: end_blk, all_done: end_done,
                         overrun_error: 1'b0, last: 1'b1};
            end
            PH_IDLE, PH_HALT:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = PH_HALT;
            end
        endcase
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (advance && (push != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (advance && (push == 2'd2))
        begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + (advance ? QCNT_W'(push) : QCNT_W'(0))
                         - (pop ? QCNT_W'(1) : QCNT_W'(0));
        end
    end

    assign head          = queue_reg[rd_ptr_reg];
    assign out_valid     = (count_reg != '0);
    assign out_byte      = head.out_byte;
    assign run_length    = head.run_length;
    assign is_prefix     = head.is_prefix;
    assign block_end     = head.block_end;
    assign all_done      = head.all_done;
    assign overrun_error = head.overrun_error;
    assign last          = head.last;

    `TIRLE_ASSERT_IMP(a_queue_bound, 1'b1, count_reg <= QCNT_W'(QDEPTH), "result queue overfilled")
    `TIRLE_ASSERT_IMP(a_err_shape, out_valid && overrun_error, (run_length == 8'd0) && last, "bad error result")
    `TIRLE_ASSERT_NXT(a_halt_sticky, phase_reg == PH_HALT, phase_reg == PH_HALT, "left halt")
    `TIRLE_ASSERT_IMP(a_rem_live, (phase_reg == PH_VALUE) || (phase_reg == PH_LIT), remaining_reg != 16'd0, "body with no size left")

endmodule
